@@ hw/rtl/xhsa_pkg.sv @@
// ----------------------------------------------------------------------------
// xhsa_pkg
// Types, constants and SHA-256 round helpers for the XOR set hash accumulator.
// ----------------------------------------------------------------------------
package xhsa_pkg;

  localparam int NumRounds = 64;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW = $clog2(QueueDepth);
  localparam int QueueCntW = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MERGE  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_XOR_INC,
    KIND_XOR_DEC,
    KIND_MERGE,
    KIND_CLEAR,
    KIND_HOLD
  } kind_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [63:0]        data_word0;
    logic [63:0]        data_word1;
    logic [63:0]        data_word2;
    logic [63:0]        data_word3;
    logic [31:0]        out_index;
    logic signed [63:0] amount;
    logic signed [31:0] block_height;
    logic [63:0]        merge_count;
  } in_t;

  typedef struct packed {
    logic [63:0] acc_word0;
    logic [63:0] acc_word1;
    logic [63:0] acc_word2;
    logic [63:0] acc_word3;
    logic [63:0] element_count;
  } out_t;

  // item tag carried alongside the hash state
  typedef struct packed {
    kind_t        kind;
    logic [255:0] data;
    logic [63:0]  count;
  } tag_t;

  typedef struct packed {
    logic [7:0][31:0]  h;   // h[0] = a ... h[7] = h
    logic [15:0][31:0] w;   // w[0] is the word used this round
    tag_t              tag;
  } stage_t;

  // work handed from front to back
  typedef struct packed {
    kind_t        kind;
    logic [255:0] xor_val;
    logic [63:0]  addend;
  } work_t;

  localparam logic [7:0][31:0] HInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [63:0][31:0] KRound = {
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // one compression round plus one message schedule step
  function automatic stage_t sha_round(input stage_t st, input logic [31:0] k);
    stage_t      r;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] s0;
    logic [31:0] s1;
    r  = st;
    t1 = st.h[7] + (rotr(st.h[4], 6) ^ rotr(st.h[4], 11) ^ rotr(st.h[4], 25))
       + ((st.h[4] & st.h[5]) ^ (~st.h[4] & st.h[6])) + k + st.w[0];
    t2 = (rotr(st.h[0], 2) ^ rotr(st.h[0], 13) ^ rotr(st.h[0], 22))
       + ((st.h[0] & st.h[1]) ^ (st.h[0] & st.h[2]) ^ (st.h[1] & st.h[2]));
    r.h[7] = st.h[6];
    r.h[6] = st.h[5];
    r.h[5] = st.h[4];
    r.h[4] = st.h[3] + t1;
    r.h[3] = st.h[2];
    r.h[2] = st.h[1];
    r.h[1] = st.h[0];
    r.h[0] = t1 + t2;
    s0 = rotr(st.w[1], 7) ^ rotr(st.w[1], 18) ^ (st.w[1] >> 3);
    s1 = rotr(st.w[14], 17) ^ rotr(st.w[14], 19) ^ (st.w[14] >> 10);
    for (int j = 0; j < 15; j++) begin
      r.w[j] = st.w[j + 1];
    end
    r.w[15] = st.w[0] + s0 + st.w[9] + s1;
    return r;
  endfunction

  // padded 48-byte record message as sixteen big-endian words
  function automatic logic [15:0][31:0] msg_words(input in_t it);
    logic [63:0][7:0]  blk;
    logic [15:0][31:0] w;
    logic [255:0]      id;
    blk = '0;
    id  = {it.data_word3, it.data_word2, it.data_word1, it.data_word0};
    for (int i = 0; i < 32; i++) begin
      blk[i] = id[8*i +: 8];
    end
    for (int i = 0; i < 4; i++) begin
      blk[32 + i] = it.out_index[8*i +: 8];
      blk[44 + i] = it.block_height[8*i +: 8];
    end
    for (int i = 0; i < 8; i++) begin
      blk[36 + i] = it.amount[8*i +: 8];
    end
    blk[48] = 8'h80;
    blk[62] = 8'h01;  // bit length 384
    blk[63] = 8'h80;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk[4*i], blk[4*i + 1], blk[4*i + 2], blk[4*i + 3]};
    end
    return w;
  endfunction

  // final feed-forward, digest byte j placed at bits 8j+7:8j
  function automatic logic [255:0] digest_bytes(input logic [7:0][31:0] st);
    logic [255:0]     d;
    logic [7:0][31:0] s;
    for (int i = 0; i < 8; i++) begin
      s[i] = HInit[i] + st[i];
    end
    for (int j = 0; j < 32; j++) begin
      d[8*j +: 8] = s[j >> 2][8*(3 - (j & 3)) +: 8];
    end
    return d;
  endfunction

endpackage

@@ hw/rtl/xhsa_front.sv @@
// ----------------------------------------------------------------------------
// xhsa_front
// Classifies items and runs a 64-stage SHA-256 round pipeline on records.
// ----------------------------------------------------------------------------
module xhsa_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  xhsa_pkg::in_t    in_data,
  output logic             wk_valid,
  input  logic             wk_full,
  output xhsa_pkg::work_t  wk_data
);

  logic                                skip_r;
  logic [xhsa_pkg::NumRounds:0]        vld_r;
  xhsa_pkg::stage_t                    stg_r [0:xhsa_pkg::NumRounds];
  xhsa_pkg::stage_t                    stg_nxt [0:xhsa_pkg::NumRounds];
  xhsa_pkg::kind_t                     kind;
  logic                                adv;

  assign adv      = !(vld_r[xhsa_pkg::NumRounds] && wk_full);
  assign in_ready = adv;
  assign wk_valid = vld_r[xhsa_pkg::NumRounds];

  always_comb begin
    unique case (xhsa_pkg::op_t'(in_data.op))
      xhsa_pkg::OP_ADD:    kind = skip_r ? xhsa_pkg::KIND_HOLD : xhsa_pkg::KIND_XOR_INC;
      xhsa_pkg::OP_REMOVE: kind = skip_r ? xhsa_pkg::KIND_HOLD : xhsa_pkg::KIND_XOR_DEC;
      xhsa_pkg::OP_MERGE:  kind = xhsa_pkg::KIND_MERGE;
      default:             kind = xhsa_pkg::KIND_CLEAR;
    endcase
  end

  always_comb begin
    stg_nxt[0].h         = xhsa_pkg::HInit;
    stg_nxt[0].w         = xhsa_pkg::msg_words(in_data);
    stg_nxt[0].tag.kind  = kind;
    stg_nxt[0].tag.data  = {in_data.data_word3, in_data.data_word2,
                            in_data.data_word1, in_data.data_word0};
    stg_nxt[0].tag.count = in_data.merge_count;
    for (int i = 0; i < xhsa_pkg::NumRounds; i++) begin
      stg_nxt[i + 1] = xhsa_pkg::sha_round(stg_r[i], xhsa_pkg::KRound[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= 1'b0;
      vld_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        skip_r <= cfg_wr_data;
      end
      if (adv) begin
        vld_r <= {vld_r[xhsa_pkg::NumRounds-1:0], in_valid};
      end
    end
  end

  // whole pipe advances together; hold all while the last stage waits on a full queue
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= xhsa_pkg::NumRounds; i++) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  always_comb begin
    wk_data.kind   = stg_r[xhsa_pkg::NumRounds].tag.kind;
    wk_data.addend = stg_r[xhsa_pkg::NumRounds].tag.count;
    unique case (stg_r[xhsa_pkg::NumRounds].tag.kind)
      xhsa_pkg::KIND_XOR_INC,
      xhsa_pkg::KIND_XOR_DEC:
        wk_data.xor_val = xhsa_pkg::digest_bytes(stg_r[xhsa_pkg::NumRounds].h);
      xhsa_pkg::KIND_MERGE:
        wk_data.xor_val = stg_r[xhsa_pkg::NumRounds].tag.data;
      default:
        wk_data.xor_val = '0;
    endcase
  end

endmodule

@@ hw/rtl/xhsa_queue.sv @@
// ----------------------------------------------------------------------------
// xhsa_queue
// Small FIFO of work items between the hash pipeline and the accumulator.
// ----------------------------------------------------------------------------
module xhsa_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  xhsa_pkg::work_t  push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output xhsa_pkg::work_t  pop_data
);

  xhsa_pkg::work_t                  mem_r [0:xhsa_pkg::QueueDepth-1];
  logic [xhsa_pkg::QueuePtrW-1:0]   wr_ptr_r;
  logic [xhsa_pkg::QueuePtrW-1:0]   rd_ptr_r;
  logic [xhsa_pkg::QueueCntW-1:0]   cnt_r;
  logic                             do_push;
  logic                             do_pop;

  assign full      = (cnt_r == xhsa_pkg::QueueCntW'(xhsa_pkg::QueueDepth));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/xhsa_back.sv @@
// ----------------------------------------------------------------------------
// xhsa_back
// Applies work items to the accumulator and count; registered result beat.
// ----------------------------------------------------------------------------
module xhsa_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wk_valid,
  output logic             wk_pop,
  input  xhsa_pkg::work_t  wk_data,
  output logic             out_valid,
  input  logic             out_ready,
  output xhsa_pkg::out_t   out_data
);

  logic [255:0]    acc_r;
  logic [255:0]    acc_nxt;
  logic [63:0]     cnt_r;
  logic [63:0]     cnt_nxt;
  logic            out_valid_r;
  xhsa_pkg::out_t  out_r;

  assign wk_pop    = wk_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    acc_nxt = acc_r ^ wk_data.xor_val;
    unique case (wk_data.kind)
      xhsa_pkg::KIND_XOR_INC: cnt_nxt = cnt_r + 64'd1;
      xhsa_pkg::KIND_XOR_DEC: cnt_nxt = (cnt_r == '0) ? '0 : cnt_r - 64'd1;
      xhsa_pkg::KIND_MERGE:   cnt_nxt = cnt_r + wk_data.addend;
      xhsa_pkg::KIND_CLEAR: begin
        cnt_nxt = '0;
        acc_nxt = '0;
      end
      default:                cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (wk_pop) begin
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wk_pop) begin
      out_r <= '{acc_word0:     acc_nxt[63:0],
                 acc_word1:     acc_nxt[127:64],
                 acc_word2:     acc_nxt[191:128],
                 acc_word3:     acc_nxt[255:192],
                 element_count: cnt_nxt};
    end
  end

endmodule

@@ hw/rtl/xor_hash_set_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// xor_hash_set_accumulator_top
// XOR multiset hash over records using SHA-256, with an element count.
// ----------------------------------------------------------------------------
// channel   | ports                             | beat
// input     | in_valid / in_ready / in_data     | one op with its record
// result    | out_valid / out_ready / out_data  | accumulator and count after it
// config    | cfg_wr_en / cfg_wr_data           | skip_updates bit
//
// One item per cycle while the queue has room; an item passes the input
// register, 64 round stages, a queue write and the result register.
// A full 4-entry queue with a valid last round stage stalls the round pipeline
// and drops in_ready; the queue drains when no result waits or it is taken.
// Synchronous active-low reset clears accumulator, count, skip and valids.
module xor_hash_set_accumulator_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  xhsa_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output xhsa_pkg::out_t  out_data
);

  logic             fr_valid;
  logic             q_full;
  xhsa_pkg::work_t  fr_work;
  logic             q_pop;
  logic             q_valid;
  xhsa_pkg::work_t  q_work;

  xhsa_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .wk_valid    (fr_valid),
    .wk_full     (q_full),
    .wk_data     (fr_work)
  );

  xhsa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fr_valid),
    .push_data (fr_work),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_work)
  );

  xhsa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wk_valid  (q_valid),
    .wk_pop    (q_pop),
    .wk_data   (q_work),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the XOR set hash accumulator: a scoreboard holds
// its own SHA-256 record hash, accumulator and count, and checks every result
// beat in order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallMax  = 19;
  localparam int DrainWait = 80;
  localparam int WatchLim  = 5000;
  localparam int NumRandom = 1500;

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  class set_scoreboard;
    logic [255:0]   acc;
    logic [63:0]    count;
    bit             skip;
    xhsa_pkg::out_t pending_q[$];
    int             mismatches;
    int             checked;

    function new();
      acc = '0;
      count = '0;
      skip = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function logic [31:0] ror32(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function logic [255:0] record_hash(xhsa_pkg::in_t it);
      logic [7:0]   m [64];
      logic [31:0]  w [64];
      logic [31:0]  hs [8];
      logic [31:0]  ra, rb, rc, rd, re, rf, rg, rh, t1, t2, s0, s1;
      logic [255:0] id;
      logic [255:0] d;
      id = {it.data_word3, it.data_word2, it.data_word1, it.data_word0};
      for (int i = 0; i < 64; i++) m[i] = 8'h00;
      for (int i = 0; i < 32; i++) m[i] = id[8*i +: 8];
      for (int i = 0; i < 4; i++) begin
        m[32 + i] = it.out_index[8*i +: 8];
        m[44 + i] = it.block_height[8*i +: 8];
      end
      for (int i = 0; i < 8; i++) m[36 + i] = it.amount[8*i +: 8];
      // padding and 384-bit length
      m[48] = 8'h80;
      m[62] = 8'h01;
      m[63] = 8'h80;
      for (int i = 0; i < 16; i++) w[i] = {m[4*i], m[4*i+1], m[4*i+2], m[4*i+3]};
      for (int i = 16; i < 64; i++) begin
        s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      ra = InitHash[0]; rb = InitHash[1]; rc = InitHash[2]; rd = InitHash[3];
      re = InitHash[4]; rf = InitHash[5]; rg = InitHash[6]; rh = InitHash[7];
      for (int i = 0; i < 64; i++) begin
        t1 = rh + (ror32(re, 6) ^ ror32(re, 11) ^ ror32(re, 25)) +
             ((re & rf) ^ (~re & rg)) + RoundConst[i] + w[i];
        t2 = (ror32(ra, 2) ^ ror32(ra, 13) ^ ror32(ra, 22)) +
             ((ra & rb) ^ (ra & rc) ^ (rb & rc));
        rh = rg; rg = rf; rf = re; re = rd + t1;
        rd = rc; rc = rb; rb = ra; ra = t1 + t2;
      end
      hs[0] = InitHash[0] + ra; hs[1] = InitHash[1] + rb;
      hs[2] = InitHash[2] + rc; hs[3] = InitHash[3] + rd;
      hs[4] = InitHash[4] + re; hs[5] = InitHash[5] + rf;
      hs[6] = InitHash[6] + rg; hs[7] = InitHash[7] + rh;
      for (int j = 0; j < 32; j++) d[8*j +: 8] = hs[j >> 2][8*(3 - (j & 3)) +: 8];
      return d;
    endfunction

    function void note_input(xhsa_pkg::in_t it);
      xhsa_pkg::out_t r;
      case (xhsa_pkg::op_t'(it.op))
        xhsa_pkg::OP_ADD, xhsa_pkg::OP_REMOVE: begin
          if (!skip) begin
            acc ^= record_hash(it);
            if (xhsa_pkg::op_t'(it.op) == xhsa_pkg::OP_ADD) count += 64'd1;
            else if (count != 0) count -= 64'd1;
          end
        end
        xhsa_pkg::OP_MERGE: begin
          acc ^= {it.data_word3, it.data_word2, it.data_word1, it.data_word0};
          count += it.merge_count;
        end
        default: begin
          acc = '0;
          count = '0;
        end
      endcase
      r.acc_word0 = acc[63:0];
      r.acc_word1 = acc[127:64];
      r.acc_word2 = acc[191:128];
      r.acc_word3 = acc[255:192];
      r.element_count = count;
      pending_q.push_back(r);
    endfunction

    function void check_result(xhsa_pkg::out_t got);
      xhsa_pkg::out_t exp_r;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      exp_r = pending_q.pop_front();
      checked++;
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on result %0d:", checked);
          $display("  acc   exp %h %h %h %h got %h %h %h %h",
                   exp_r.acc_word3, exp_r.acc_word2, exp_r.acc_word1, exp_r.acc_word0,
                   got.acc_word3, got.acc_word2, got.acc_word1, got.acc_word0);
          $display("  count exp %h got %h", exp_r.element_count, got.element_count);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  xhsa_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  xhsa_pkg::out_t out_data;

  set_scoreboard sb = new();
  bit tx_burst = 0;
  bit rx_burst = 0;
  int sent = 0;
  int idle_cycles = 0;
  int op_seen [4] = '{0, 0, 0, 0};

  always #5 clk = ~clk;

  xor_hash_set_accumulator_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_input(in_data);
      op_seen[in_data.op]++;
    end
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLim) begin
      $display("timeout: no beat for %0d cycles", WatchLim);
      $display("xor_hash_set_accumulator_top regression: fail");
      $finish;
    end
  end

  // result side: random stall before each beat, with stall-free stretches
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_burst = ~rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, StallMax);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // hold valid and payload until the beat is taken; keep valid high on zero gap
  task automatic send_item(xhsa_pkg::in_t it);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, StallMax);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!(in_valid && in_ready));
    sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
  endtask

  task automatic write_skip(bit v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.skip = v;
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7fff_ffff_ffff_ffff;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic xhsa_pkg::in_t make_item(xhsa_pkg::op_t op);
    xhsa_pkg::in_t it;
    logic [63:0]   r;
    it.op = op;
    it.data_word0 = rand64();
    it.data_word1 = rand64();
    it.data_word2 = rand64();
    it.data_word3 = rand64();
    r = rand64();
    it.out_index = r[31:0];
    it.amount = rand64();
    r = rand64();
    it.block_height = r[31:0];
    // mostly small merge counts so add/remove reach both ends of the count
    case ($urandom_range(0, 3))
      0: it.merge_count = rand64();
      1: it.merge_count = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 3));
      default: it.merge_count = 64'($urandom_range(0, 7));
    endcase
    return it;
  endfunction

  function automatic xhsa_pkg::in_t fixed_item(xhsa_pkg::op_t op, logic [63:0] v,
                                               logic [63:0] cnt);
    xhsa_pkg::in_t it;
    it = '{op: op, data_word0: v, data_word1: v, data_word2: v, data_word3: v,
           out_index: v[31:0], amount: v, block_height: v[31:0], merge_count: cnt};
    return it;
  endfunction

  function automatic xhsa_pkg::op_t pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return xhsa_pkg::OP_ADD;
    if (r < 80) return xhsa_pkg::OP_REMOVE;
    if (r < 95) return xhsa_pkg::OP_MERGE;
    return xhsa_pkg::OP_CLEAR;
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every op, count wrap and saturation, skip behavior
    write_skip(1'b0);
    send_item(fixed_item(xhsa_pkg::OP_ADD, '0, '0));
    send_item(fixed_item(xhsa_pkg::OP_ADD, '1, '0));
    send_item(fixed_item(xhsa_pkg::OP_REMOVE, '1, '1));
    send_item(fixed_item(xhsa_pkg::OP_REMOVE, 64'h0123_4567_89ab_cdef, '0));
    send_item(fixed_item(xhsa_pkg::OP_REMOVE, 64'h8000_0000_8000_0000, '0));
    send_item(fixed_item(xhsa_pkg::OP_MERGE, '1, '1));
    send_item(fixed_item(xhsa_pkg::OP_ADD, 64'h7fff_ffff_7fff_ffff, '0));
    send_item(fixed_item(xhsa_pkg::OP_MERGE, '1, 64'd5));
    send_item(fixed_item(xhsa_pkg::OP_MERGE, '0, '1));
    send_item(fixed_item(xhsa_pkg::OP_CLEAR, '1, '1));
    send_item(fixed_item(xhsa_pkg::OP_MERGE, 64'hdead_beef_cafe_f00d, '1));
    send_item(fixed_item(xhsa_pkg::OP_ADD, 64'h5555_5555_5555_5555, '0));
    send_item(fixed_item(xhsa_pkg::OP_ADD, 64'haaaa_aaaa_aaaa_aaaa, '0));
    write_skip(1'b1);
    send_item(fixed_item(xhsa_pkg::OP_ADD, '1, '0));
    send_item(fixed_item(xhsa_pkg::OP_REMOVE, '0, '1));
    send_item(fixed_item(xhsa_pkg::OP_MERGE, 64'h1234_0000_0000_5678, 64'd3));
    send_item(fixed_item(xhsa_pkg::OP_CLEAR, '0, '0));
    send_item(fixed_item(xhsa_pkg::OP_REMOVE, '1, '0));
    write_skip(1'b0);
    send_item(fixed_item(xhsa_pkg::OP_REMOVE, 64'h0f0f_0f0f_0f0f_0f0f, '0));

    // random phases, skip mostly off
    for (int ph = 0; ph < 8; ph++) begin
      write_skip((ph % 4) == 3);
      for (int i = 0; i < NumRandom / 8; i++) begin
        if ($urandom_range(0, 31) == 0) tx_burst = ~tx_burst;
        send_item(make_item(pick_op()));
      end
    end
    tx_burst = 0;

    wait_drained();
    if (sb.pending_q.size() != 0) sb.mismatches++;
    $display("sent %0d items (add %0d, remove %0d, merge %0d, clear %0d), checked %0d results",
             sent, op_seen[0], op_seen[1], op_seen[2], op_seen[3], sb.checked);
    $display("skip toggled across phases, random stalls on both channels, %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("xor_hash_set_accumulator_top regression: pass");
    end else begin
      $display("xor_hash_set_accumulator_top regression: fail");
    end
    $finish;
  end

endmodule
